/* design/rvp_pkg.sv */
// Shared widths, payload types and step functions for the radial vignette pipeline.
// No dependencies; used by rvp_isqrt, rvp_div and radial_vignette_pixel.
`timescale 1ns / 1ps

package rvp_pkg;

	// Field widths
	localparam int DIM_W    = 13;
	localparam int COORD_W  = 12;
	localparam int CH_W     = 8;
	localparam int NCH      = 3;

	// Squared distance and its root
	localparam int SQ_W          = 2 * COORD_W + 1;
	localparam int ROOT_W        = 13;
	localparam int SQ_ITERS      = (SQ_W + 1) / 2;
	localparam int SQ_PER_STAGE  = 2;
	localparam int SQ_STAGES     = (SQ_ITERS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

	// Channel product and restoring division
	localparam int PROD_W        = CH_W + DIM_W;
	localparam int DIV_STEPS     = CH_W;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b1;

	// Colors and divisor that ride alongside the distance math
	typedef struct packed {
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic [DIM_W-1:0] h;
	} pix_side_t;

	// Bit-serial square root: remaining operand and partial root
	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] res;
	} sqrt_st_t;

	// Restoring division: remainder and quotient bits so far
	typedef struct packed {
		logic [PROD_W-1:0] rem;
		logic [CH_W-1:0]   q;
	} div_st_t;

	// One square root iteration for the given trial bit
	function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [SQ_W-1:0] bitv);
		logic [SQ_W:0] trial;
		sqrt_st_t      nx;
		trial = {1'b0, st.res} + {1'b0, bitv};
		if ({1'b0, st.v} >= trial) begin
			nx.v   = st.v - trial[SQ_W-1:0];
			nx.res = (st.res >> 1) + bitv;
		end else begin
			nx.v   = st.v;
			nx.res = st.res >> 1;
		end
		return nx;
	endfunction

	// One quotient bit against the shifted divisor, most significant first
	function automatic div_st_t div_step(div_st_t st, logic [PROD_W-1:0] dsh);
		div_st_t nx;
		if (st.rem >= dsh) begin
			nx.rem = st.rem - dsh;
			nx.q   = {st.q[CH_W-2:0], 1'b1};
		end else begin
			nx.rem = st.rem;
			nx.q   = {st.q[CH_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

/* design/rvp_isqrt.sv */
// Pipelined integer square root, two iterations per stage, with a sideband payload.
// Depends on rvp_pkg for widths, types and the iteration function.
`timescale 1ns / 1ps

module rvp_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_i,
	input  logic [rvp_pkg::SQ_W-1:0]  sq_i,
	input  rvp_pkg::pix_side_t        side_i,
	output logic                      valid_o,
	output logic [rvp_pkg::ROOT_W-1:0] root_o,
	output rvp_pkg::pix_side_t        side_o
);

	localparam int SQW    = rvp_pkg::SQ_W;
	localparam int NSTG   = rvp_pkg::SQ_STAGES;
	localparam int PER    = rvp_pkg::SQ_PER_STAGE;
	localparam int ITERS  = rvp_pkg::SQ_ITERS;

	logic                valid_s [NSTG];
	rvp_pkg::sqrt_st_t   st_s    [NSTG];
	rvp_pkg::pix_side_t  side_s  [NSTG];

	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		logic               src_valid;
		rvp_pkg::sqrt_st_t  src_st;
		rvp_pkg::pix_side_t src_side;
		rvp_pkg::sqrt_st_t  nxt_st;

		// Select the stage input
		if (s == 0) begin : g_first
			assign src_valid = valid_i;
			assign src_st    = '{v: sq_i, res: '0};
			assign src_side  = side_i;
		end else begin : g_next
			assign src_valid = valid_s[s-1];
			assign src_st    = st_s[s-1];
			assign src_side  = side_s[s-1];
		end

		// Run this stage's iterations, highest trial bit first
		always_comb begin
			nxt_st = src_st;
			for (int j = 0; j < PER; j++) begin
				if (s * PER + j < ITERS) begin
					nxt_st = rvp_pkg::sqrt_step(nxt_st, SQW'(1) << (SQW - 1 - 2 * (s * PER + j)));
				end
			end
		end

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[s] <= 1'b0;
			end else if (en) begin
				valid_s[s] <= src_valid;
			end
		end

		// Advance the payload
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[s]   <= nxt_st;
				side_s[s] <= src_side;
			end
		end
	end

	assign valid_o = valid_s[NSTG-1];
	assign root_o  = st_s[NSTG-1].res[rvp_pkg::ROOT_W-1:0];
	assign side_o  = side_s[NSTG-1];

endmodule

/* design/rvp_div.sv */
// Pipelined restoring division of three channel products by the image height.
// Depends on rvp_pkg; two quotient bits per stage, result forced to zero on request.
`timescale 1ns / 1ps

module rvp_div (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         valid_i,
	input  logic                                         zero_i,
	input  logic [rvp_pkg::DIM_W-1:0]                    h_i,
	input  logic [rvp_pkg::NCH-1:0][rvp_pkg::PROD_W-1:0] prod_i,
	output logic                                         valid_o,
	output logic [rvp_pkg::NCH-1:0][rvp_pkg::CH_W-1:0]   q_o
);

	localparam int PW    = rvp_pkg::PROD_W;
	localparam int NSTG  = rvp_pkg::DIV_STAGES;
	localparam int PER   = rvp_pkg::DIV_PER_STAGE;
	localparam int STEPS = rvp_pkg::DIV_STEPS;
	localparam int NCH   = rvp_pkg::NCH;

	logic                        valid_s [NSTG];
	logic                        zero_s  [NSTG];
	logic [rvp_pkg::DIM_W-1:0]   h_s     [NSTG];
	rvp_pkg::div_st_t            st_s    [NSTG][NCH];

	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		logic                      src_valid;
		logic                      src_zero;
		logic [rvp_pkg::DIM_W-1:0] src_h;
		rvp_pkg::div_st_t          src_st [NCH];
		rvp_pkg::div_st_t          nxt_st [NCH];

		// Select the stage input
		if (s == 0) begin : g_first
			assign src_valid = valid_i;
			assign src_zero  = zero_i;
			assign src_h     = h_i;
			for (genvar c = 0; c < NCH; c++) begin : g_ch
				assign src_st[c] = '{rem: prod_i[c], q: '0};
			end
		end else begin : g_next
			assign src_valid = valid_s[s-1];
			assign src_zero  = zero_s[s-1];
			assign src_h     = h_s[s-1];
			for (genvar c = 0; c < NCH; c++) begin : g_ch
				assign src_st[c] = st_s[s-1][c];
			end
		end

		// Subtract the shifted divisor where it fits, for every channel
		always_comb begin
			for (int c = 0; c < NCH; c++) begin
				nxt_st[c] = src_st[c];
				for (int j = 0; j < PER; j++) begin
					if (s * PER + j < STEPS) begin
						nxt_st[c] = rvp_pkg::div_step(nxt_st[c],
							PW'(src_h) << (STEPS - 1 - (s * PER + j)));
					end
				end
			end
		end

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[s] <= 1'b0;
			end else if (en) begin
				valid_s[s] <= src_valid;
			end
		end

		// Advance the payload
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[s] <= src_zero;
				h_s[s]    <= src_h;
				for (int c = 0; c < NCH; c++) begin
					st_s[s][c] <= nxt_st[c];
				end
			end
		end
	end

	// Clamp to zero where the pixel lies at or beyond the falloff radius
	assign valid_o = valid_s[NSTG-1];
	for (genvar c = 0; c < NCH; c++) begin : g_out
		assign q_o[c] = zero_s[NSTG-1] ? '0 : st_s[NSTG-1][c].q;
	end

endmodule

/* design/radial_vignette_pixel.sv */
// Radial vignette: throughput one pixel per cycle while the output is not stalled, set
// by the fully pipelined square root (two iterations per stage) and divider (two
// quotient bits per stage). A stalled output freezes the whole pipeline, so the
// input stalls only while a result waits at the output.
// arst_n clears all valid bits and sets both size registers to 1.
`timescale 1ns / 1ps

module radial_vignette_pixel #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write transaction
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rvp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rvp_pkg::DIM_W-1:0]      cfg_data,
	// pixel input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rvp_pkg::COORD_W-1:0]    pixel_row,
	input  logic [rvp_pkg::COORD_W-1:0]    pixel_col,
	input  logic [rvp_pkg::CH_W-1:0]       red_in,
	input  logic [rvp_pkg::CH_W-1:0]       green_in,
	input  logic [rvp_pkg::CH_W-1:0]       blue_in,
	// pixel output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rvp_pkg::CH_W-1:0]       red_out,
	output logic [rvp_pkg::CH_W-1:0]       green_out,
	output logic [rvp_pkg::CH_W-1:0]       blue_out
);

	localparam int DW   = rvp_pkg::DIM_W;
	localparam int CW   = rvp_pkg::COORD_W;
	localparam int SQW  = rvp_pkg::SQ_W;
	localparam int SQHW = 2 * rvp_pkg::COORD_W;
	localparam int PW   = rvp_pkg::PROD_W;
	localparam int NCH  = rvp_pkg::NCH;

	// Map zero to one and saturate at the largest supported size
	function automatic logic [DW-1:0] clamp_dim(logic [DW-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DW'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic          en;
	logic [DW-1:0] h_q;
	logic [DW-1:0] w_q;

	// Freeze every stage while a result is held at the output
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Size registers, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= DW'(1);
			w_q <= DW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rvp_pkg::CFG_IDX_HEIGHT: h_q <= clamp_dim(cfg_data);
				rvp_pkg::CFG_IDX_WIDTH:  w_q <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	// Stage 1: offsets from the center and their magnitudes
	logic [CW:0]        dx;
	logic [CW:0]        dy;
	logic [CW:0]        ndx;
	logic [CW:0]        ndy;
	logic               valid_s1;
	logic [CW-1:0]      adx_s1;
	logic [CW-1:0]      ady_s1;
	rvp_pkg::pix_side_t side_s1;

	assign dx  = {1'b0, pixel_col} - {1'b0, w_q[DW-1:1]};
	assign dy  = {1'b0, pixel_row} - {1'b0, h_q[DW-1:1]};
	assign ndx = -dx;
	assign ndy = -dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1  <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
			ady_s1  <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
			side_s1 <= '{r: red_in, g: green_in, b: blue_in, h: h_q};
		end
	end

	// Stage 2: square each offset
	logic               valid_s2;
	logic [SQHW-1:0]    sqx_s2;
	logic [SQHW-1:0]    sqy_s2;
	rvp_pkg::pix_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= SQHW'(adx_s1) * SQHW'(adx_s1);
			sqy_s2  <= SQHW'(ady_s1) * SQHW'(ady_s1);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: squared distance
	logic               valid_s3;
	logic [SQW-1:0]     sum_s3;
	rvp_pkg::pix_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= SQW'(sqx_s2) + SQW'(sqy_s2);
			side_s3 <= side_s2;
		end
	end

	// Stages 4 to 10: integer square root
	logic                       sq_valid;
	logic [rvp_pkg::ROOT_W-1:0] sq_root;
	rvp_pkg::pix_side_t         sq_side;

	rvp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (valid_s3),
		.sq_i    (sum_s3),
		.side_i  (side_s3),
		.valid_o (sq_valid),
		.root_o  (sq_root),
		.side_o  (sq_side)
	);

	// Stage 11: falloff numerator and the beyond-radius flag
	logic               valid_s11;
	logic               zero_s11;
	logic [DW-1:0]      num_s11;
	rvp_pkg::pix_side_t side_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (en) begin
			valid_s11 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s11 <= DW'(sq_root) >= sq_side.h;
			num_s11  <= sq_side.h - DW'(sq_root);
			side_s11 <= sq_side;
		end
	end

	// Stage 12: scale each channel by the numerator
	logic                   valid_s12;
	logic                   zero_s12;
	logic [DW-1:0]          h_s12;
	logic [NCH-1:0][PW-1:0] prod_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s12    <= zero_s11;
			h_s12       <= side_s11.h;
			prod_s12[0] <= PW'(side_s11.r) * PW'(num_s11);
			prod_s12[1] <= PW'(side_s11.g) * PW'(num_s11);
			prod_s12[2] <= PW'(side_s11.b) * PW'(num_s11);
		end
	end

	// Stages 13 to 16: divide by the height
	logic [NCH-1:0][rvp_pkg::CH_W-1:0] quot;

	rvp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (valid_s12),
		.zero_i  (zero_s12),
		.h_i     (h_s12),
		.prod_i  (prod_s12),
		.valid_o (out_valid),
		.q_o     (quot)
	);

	assign red_out   = quot[0];
	assign green_out = quot[1];
	assign blue_out  = quot[2];

endmodule

/* tb/sv/radial_vignette_pixel_tb.sv */
// Self-checking bench for radial_vignette_pixel: directed corners, size clamps and a random stream.
// Depends on rvp_pkg (widths, register indexes) and the radial_vignette_pixel RTL.
`timescale 1ns / 1ps

module radial_vignette_pixel_tb;

	localparam int CH_W           = rvp_pkg::CH_W;
	localparam int DIM_W          = rvp_pkg::DIM_W;
	localparam int COORD_W        = rvp_pkg::COORD_W;
	localparam int CFG_IDX_W      = rvp_pkg::CFG_IDX_W;
	localparam int DIM_LIMIT      = 4096;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int LATENCY_GUARD  = 24;
	localparam int ITEMS_PER_SIZE = 200;
	localparam int MAX_PRINTS     = 100;
	localparam longint TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = rvp_pkg::CFG_IDX_HEIGHT;
	logic [DIM_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] pixel_row = '0;
	logic [COORD_W-1:0] pixel_col = '0;
	logic [CH_W-1:0] red_in = '0;
	logic [CH_W-1:0] green_in = '0;
	logic [CH_W-1:0] blue_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CH_W-1:0] red_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] blue_out;

	// shadow of the size registers, raw as written
	logic [DIM_W-1:0] h_reg;
	logic [DIM_W-1:0] w_reg;
	shade_t shade_q[$];
	int err_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	radial_vignette_pixel #(
		.MAX_DIM(DIM_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_row(pixel_row),
		.pixel_col(pixel_col),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out)
	);

	always #(CLK_HALF) clk = ~clk;

	// Size as the block uses it: zero reads as one, saturate at the limit
	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > DIM_LIMIT) return DIM_LIMIT;
		return v;
	endfunction

	// Darken one pixel by its distance from the image center
	function automatic shade_t vignette_shade(logic [DIM_W-1:0] hv, logic [DIM_W-1:0] wv,
			logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
			logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		int unsigned h, w, adx, ady, sq, radius, trial, num;
		int dx, dy;
		shade_t s;
		h = eff_dim(hv);
		w = eff_dim(wv);
		dx = int'(col) - int'(w / 2);
		dy = int'(row) - int'(h / 2);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		sq = adx * adx + ady * ady;
		// floor of the root, one bit at a time from the top
		radius = 0;
		for (int i = 13; i >= 0; i--) begin
			trial = radius | (32'd1 << i);
			if (trial * trial <= sq) radius = trial;
		end
		if (radius >= h) begin
			s = '0;
		end else begin
			num = h - radius;
			s.r = CH_W'((r * num) / h);
			s.g = CH_W'((g * num) / h);
			s.b = CH_W'((b * num) / h);
		end
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		// keep counting past the print cap so a broken run stays readable
		if (err_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Track register writes and predict each accepted pixel transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			h_reg <= 13'd1;
			w_reg <= 13'd1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rvp_pkg::CFG_IDX_HEIGHT) h_reg <= cfg_data;
				else w_reg <= cfg_data;
			end
			if (in_valid && !in_stall)
				shade_q.push_back(vignette_shade(h_reg, w_reg, pixel_row, pixel_col,
					red_in, green_in, blue_in));
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		shade_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (shade_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
					red_out, green_out, blue_out));
			end else begin
				want = shade_q.pop_front();
				if (red_out !== want.r || green_out !== want.g || blue_out !== want.b)
					report_mismatch($sformatf("got %0d/%0d/%0d want %0d/%0d/%0d",
						red_out, green_out, blue_out, want.r, want.g, want.b));
			end
		end
	end

	// Random output backpressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Send one pixel transaction; enter and leave on a falling edge
	task automatic send_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
			logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_row <= row;
		pixel_col <= col;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Hold input low until all results are back, then let the pipe empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (shade_q.size() != 0) @(negedge clk);
		repeat (LATENCY_GUARD) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_size(logic [DIM_W-1:0] hv, logic [DIM_W-1:0] wv);
		wait_drained();
		cfg_write(rvp_pkg::CFG_IDX_HEIGHT, hv);
		cfg_write(rvp_pkg::CFG_IDX_WIDTH, wv);
	endtask

	// Sizes out of reset are one by one: only the origin keeps its color
	task automatic test_reset_sizes();
		send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd0, 12'd1, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
	endtask

	// Zero reads as one; values past the limit saturate
	task automatic test_size_clamps();
		set_size(13'd0, 13'd0);
		send_pixel(12'd0, 12'd0, 8'd200, 8'd100, 8'd50);
		set_size(13'd8191, 13'd4097);
		send_pixel(12'd2048, 12'd2048, 8'd255, 8'd128, 8'd1);
		send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd255);
		set_size(13'd4096, 13'd1);
		send_pixel(12'd2048, 12'd0, 8'd170, 8'd85, 8'd255);
	endtask

	// Distance at and just under the height, pixels outside the image, odd sizes
	task automatic test_edge_pixels();
		set_size(13'd16, 13'd16);
		send_pixel(12'd24, 12'd8, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd23, 12'd8, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd8, 12'd8, 8'd0, 8'd255, 8'd0);
		send_pixel(12'd0, 12'd0, 8'd255, 8'd127, 8'd128);
		send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd8, 12'd4095, 8'd255, 8'd255, 8'd255);
		set_size(13'd3, 13'd5);
		send_pixel(12'd1, 12'd2, 8'd255, 8'd1, 8'd254);
		send_pixel(12'd2, 12'd2, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd0, 12'd0, 8'd99, 8'd200, 8'd255);
		send_pixel(12'd3, 12'd2, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd4, 12'd2, 8'd255, 8'd255, 8'd255);
	endtask

	function automatic logic [CH_W-1:0] pick_channel();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return 8'd0;
		if (sel == 1) return 8'd255;
		return CH_W'($urandom_range(255));
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
		int unsigned lim;
		lim = eff_dim(dim) + eff_dim(dim) / 2;
		if (lim > 4095) lim = 4095;
		// mostly in and just around the image, sometimes anywhere
		if ($urandom_range(99) < 75) return COORD_W'($urandom_range(lim));
		return COORD_W'($urandom_range(4095));
	endfunction

	// Random pixels at two sizes under one idle/stall mix; pause mid-way through each size
	task automatic test_random_stream(int idle, int stall,
			logic [DIM_W-1:0] h0, logic [DIM_W-1:0] w0,
			logic [DIM_W-1:0] h1, logic [DIM_W-1:0] w1);
		logic [DIM_W-1:0] hv, wv;
		for (int s = 0; s < 2; s++) begin
			hv = (s == 0) ? h0 : h1;
			wv = (s == 0) ? w0 : w1;
			set_size(hv, wv);
			idle_pct = idle;
			stall_pct = stall;
			for (int n = 0; n < ITEMS_PER_SIZE; n++) begin
				if (n == ITEMS_PER_SIZE / 2) wait_drained();
				send_pixel(pick_coord(hv), pick_coord(wv),
					pick_channel(), pick_channel(), pick_channel());
			end
			idle_pct = 0;
			stall_pct = 0;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_sizes();
		test_size_clamps();
		test_edge_pixels();
		test_random_stream(0, 0, 13'd480, 13'd640, 13'd4096, 13'd4096);
		test_random_stream(59, 0, 13'd1, 13'd1, 13'd16, 13'd4000);
		test_random_stream(0, 59, 13'd8191, 13'd0, 13'd3, 13'd5);
		test_random_stream(11, 11, DIM_W'($urandom_range(1, 4096)),
			DIM_W'($urandom_range(1, 4096)), 13'd100, 13'd8191);
		wait_drained();
		if (shade_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", shade_q.size()));
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
